// ----- src/mwm_pkg.sv -----
package mwm_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 6;
   localparam int DATA_BITS_DEFAULT    = 16;

   localparam int RETRY_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;

   localparam logic [RETRY_BITS-1:0] RETRY_LIMIT_RESET = 4'd10;
   localparam logic                  WRAP_WRITES_RESET = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RETRY_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRAP_WRITES = 2'd1;

   // Microwire opcode codes 2'b.. sent after the start bit
   localparam logic [1:0] CODE_READ  = 2'b10;
   localparam logic [1:0] CODE_WRITE = 2'b01;
   localparam logic [1:0] CODE_ERASE = 2'b11;
   localparam logic [1:0] CODE_EXT   = 2'b00;

   // extended commands: top two address bits
   localparam logic [1:0] EXT_WRAL = 2'b01;
   localparam logic [1:0] EXT_ERAL = 2'b10;
   localparam logic [1:0] EXT_EWEN = 2'b11;
   localparam logic [1:0] EXT_EWDS = 2'b00;

   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_WRAL  = 3'd2,
      OP_ERASE = 3'd3,
      OP_ERAL  = 3'd4,
      OP_EWEN  = 3'd5,
      OP_EWDS  = 3'd6
   } opcode_type;

endpackage

// ----- src/microwire_eeprom_command_master_core.sv -----
// Microwire master for a 93C46-style serial EEPROM. Each accepted req_ item is one
// tick of the serial sequence: it carries an optional command (taken only while idle,
// opcode seven ignored) and the DO level sampled on that tick, and it yields exactly
// one rsp_ item with the CS, SK and DI levels for that tick plus busy, done and the
// last read result. Pin levels follow the state before the tick; the DO sample then
// moves the state. A command raises CS, waits for DO high, then sends start bit,
// opcode and address (and the data word for writes), one SK-high and one SK-low tick
// per bit. With wrap_writes set, write, write-all, erase and erase-all are framed by
// EWEN and EWDS. Reads check the dummy zero and retry up to retry_limit attempts,
// or one attempt when it is zero. One item is taken every clock cycle unless a
// finished result in the result register, the single register stage behind the
// input handshake, is not taken; only then does the core stall.
module microwire_eeprom_command_master_core #(
   parameter int ADDRESS_BITS = mwm_pkg::ADDRESS_BITS_DEFAULT,
   parameter int DATA_BITS    = mwm_pkg::DATA_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [mwm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mwm_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_start_req,
   input  logic [2:0]                         req_opcode,
   input  logic [ADDRESS_BITS-1:0]            req_word_address,
   input  logic [DATA_BITS-1:0]               req_write_word,
   input  logic                               req_serial_data_from_memory,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_chip_select,
   output logic                               rsp_serial_clock,
   output logic                               rsp_serial_data_to_memory,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic [DATA_BITS-1:0]               rsp_read_word,
   output logic                               rsp_read_failed
);
   import mwm_pkg::*;

   localparam int HEAD_BITS  = 3 + ADDRESS_BITS;
   localparam int FRAME_BITS = HEAD_BITS + DATA_BITS;
   localparam int CNT_BITS   = $clog2(FRAME_BITS + 1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_SELECT, PH_BIT_HI, PH_BIT_LO, PH_IN_HI, PH_IN_LO, PH_END, PH_RETRY
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [1:0]                step_ff, step_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in, cnt_dec;
   logic [FRAME_BITS-1:0]     out_shift_ff, out_shift_in, bit_sel;
   logic [DATA_BITS-1:0]      in_shift_ff, in_shift_in;
   logic [RETRY_BITS-1:0]     attempt_ff, attempt_in;
   logic                      wrap_ff, wrap_in;
   opcode_type                op_ff, op_in;
   logic [ADDRESS_BITS-1:0]   addr_ff, addr_in;
   logic [DATA_BITS-1:0]      data_ff, data_in;
   logic [RETRY_BITS-1:0]     retry_limit_ff;
   logic                      wrap_writes_ff;
   logic                      rsp_valid_ff;
   logic                      cs_ff, sk_ff, di_ff, busy_ff, done_ff, done_in;
   logic [DATA_BITS-1:0]      word_ff, word_in;
   logic                      failed_ff, failed_in;
   logic                      accept, load, cs_now, sk_now, di_now, busy_now, dout;
   logic [RETRY_BITS-1:0]     limit;
   opcode_type                kind_cur, kind_ld;

   function automatic logic is_wrapped(logic wrap, opcode_type op);
      return wrap && (op == OP_WRITE || op == OP_WRAL || op == OP_ERASE || op == OP_ERAL);
   endfunction

   function automatic opcode_type current_kind(logic wrap, opcode_type op, logic [1:0] step);
      opcode_type kind;
      kind = op;
      if (is_wrapped(wrap, op)) begin
         if (step == 2'd0) kind = OP_EWEN;
         else if (step >= 2'd2) kind = OP_EWDS;
      end
      return kind;
   endfunction

   function automatic logic has_data(opcode_type kind);
      return kind == OP_WRITE || kind == OP_WRAL;
   endfunction

   function automatic logic [FRAME_BITS-1:0] frame_value(opcode_type kind,
                                                         logic [ADDRESS_BITS-1:0] addr,
                                                         logic [DATA_BITS-1:0] data);
      logic [1:0]              code;
      logic [ADDRESS_BITS-1:0] field;
      logic [HEAD_BITS-1:0]    head;
      logic [FRAME_BITS-1:0]   frame;
      code  = CODE_EXT;
      field = '0;
      unique case (kind)
         OP_READ:  begin code = CODE_READ;  field = addr; end
         OP_WRITE: begin code = CODE_WRITE; field = addr; end
         OP_WRAL:  field = {EXT_WRAL, {(ADDRESS_BITS-2){1'b0}}};
         OP_ERASE: begin code = CODE_ERASE; field = addr; end
         OP_ERAL:  field = {EXT_ERAL, {(ADDRESS_BITS-2){1'b0}}};
         OP_EWEN:  field = {EXT_EWEN, {(ADDRESS_BITS-2){1'b0}}};
         default:  field = {EXT_EWDS, {(ADDRESS_BITS-2){1'b0}}};
      endcase
      head = {1'b1, code, field};
      if (has_data(kind)) frame = {head, data};
      else frame = {{DATA_BITS{1'b0}}, head};
      return frame;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign dout      = req_serial_data_from_memory;
   assign limit     = (retry_limit_ff == '0) ? RETRY_BITS'(1) : retry_limit_ff;
   assign kind_cur  = current_kind(wrap_ff, op_ff, step_ff);
   assign cnt_dec   = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;

   // pin levels come from the state before this tick
   assign cs_now   = !(phase_ff == PH_IDLE || phase_ff == PH_END || phase_ff == PH_RETRY);
   assign sk_now   = (phase_ff == PH_BIT_HI || phase_ff == PH_IN_HI);
   assign busy_now = (phase_ff != PH_IDLE);
   assign bit_sel  = out_shift_ff >> (cnt_ff - 1'b1);
   assign di_now   = (phase_ff == PH_BIT_HI || phase_ff == PH_BIT_LO) && (cnt_ff != '0)
                     && bit_sel[0];

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      attempt_in   = attempt_ff;
      wrap_in      = wrap_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      word_in      = word_ff;
      failed_in    = failed_ff;
      done_in      = 1'b0;
      load         = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_start_req && req_opcode <= OP_EWDS) begin
               wrap_in    = wrap_writes_ff;
               op_in      = opcode_type'(req_opcode);
               addr_in    = req_word_address;
               data_in    = req_write_word;
               step_in    = 2'd0;
               attempt_in = '0;
               load       = 1'b1;
               phase_in   = PH_SELECT;
            end
         end
         PH_SELECT: begin
            if (dout) phase_in = PH_BIT_HI;
         end
         PH_BIT_HI: phase_in = PH_BIT_LO;
         PH_BIT_LO: begin
            cnt_in = cnt_dec;
            if (cnt_dec != '0) begin
               phase_in = PH_BIT_HI;
            end else if (kind_cur != OP_READ) begin
               phase_in = PH_END;
            end else if (!dout) begin
               in_shift_in = '0;
               cnt_in      = CNT_BITS'(DATA_BITS);
               phase_in    = PH_IN_HI;
            end else begin
               attempt_in = attempt_ff + 1'b1;
               if (attempt_in >= limit) begin
                  word_in   = '1;
                  failed_in = 1'b1;
                  phase_in  = PH_END;
               end else begin
                  phase_in = PH_RETRY;
               end
            end
         end
         PH_IN_HI: phase_in = PH_IN_LO;
         PH_IN_LO: begin
            in_shift_in = {in_shift_ff[DATA_BITS-2:0], dout};
            cnt_in      = cnt_dec;
            if (cnt_dec == '0) begin
               word_in   = in_shift_in;
               failed_in = 1'b0;
               phase_in  = PH_END;
            end else begin
               phase_in = PH_IN_HI;
            end
         end
         PH_RETRY: begin
            load     = 1'b1;
            phase_in = PH_SELECT;
         end
         PH_END: begin
            if (is_wrapped(wrap_ff, op_ff) && step_ff < 2'd2) begin
               step_in  = step_ff + 1'b1;
               load     = 1'b1;
               phase_in = PH_SELECT;
            end else begin
               step_in  = 2'd0;
               cnt_in   = '0;
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
      endcase
      kind_ld = current_kind(wrap_in, op_in, step_in);
      if (load) begin
         out_shift_in = frame_value(kind_ld, addr_in, data_in);
         cnt_in       = has_data(kind_ld) ? CNT_BITS'(FRAME_BITS) : CNT_BITS'(HEAD_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
         wrap_writes_ff <= WRAP_WRITES_RESET;
         phase_ff       <= PH_IDLE;
         step_ff        <= 2'd0;
         cnt_ff         <= '0;
         out_shift_ff   <= '0;
         in_shift_ff    <= '0;
         attempt_ff     <= '0;
         wrap_ff        <= 1'b0;
         op_ff          <= OP_READ;
         addr_ff        <= '0;
         data_ff        <= '0;
         word_ff        <= '0;
         failed_ff      <= 1'b0;
         cs_ff          <= 1'b0;
         sk_ff          <= 1'b0;
         di_ff          <= 1'b0;
         busy_ff        <= 1'b0;
         done_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_RETRY_LIMIT) retry_limit_ff <= csr_write_data;
            else if (csr_index == CSR_WRAP_WRITES) wrap_writes_ff <= csr_write_data[0];
         end
         if (accept) begin
            phase_ff     <= phase_in;
            step_ff      <= step_in;
            cnt_ff       <= cnt_in;
            out_shift_ff <= out_shift_in;
            in_shift_ff  <= in_shift_in;
            attempt_ff   <= attempt_in;
            wrap_ff      <= wrap_in;
            op_ff        <= op_in;
            addr_ff      <= addr_in;
            data_ff      <= data_in;
            word_ff      <= word_in;
            failed_ff    <= failed_in;
            cs_ff        <= cs_now;
            sk_ff        <= sk_now;
            di_ff        <= di_now;
            busy_ff      <= busy_now;
            done_ff      <= done_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_chip_select           = cs_ff;
   assign rsp_serial_clock          = sk_ff;
   assign rsp_serial_data_to_memory = di_ff;
   assign rsp_busy_res              = busy_ff;
   assign rsp_done_res              = done_ff;
   assign rsp_read_word             = word_ff;
   assign rsp_read_failed           = failed_ff;

   a_done_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_busy_res && !rsp_chip_select && !rsp_serial_clock))
      else $error("done item without busy or with CS/SK high");

   a_sk_needs_cs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_serial_clock) |-> rsp_chip_select)
      else $error("SK high while CS low");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_BITS'(FRAME_BITS)) && (step_ff <= 2'd2))
      else $error("bit counter or sub-command step out of range");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_END && phase_in == PH_IDLE) |=> (cnt_ff == '0 && step_ff == 2'd0))
      else $error("sequence ended without clearing counters");

endmodule
